>>> hw/rtl/union_find_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checkers of the union-find engine.
// Each macro expands to one labeled concurrent assertion that reports by
// $error when it fails.
// ---------------------------------------------------------------------------
`ifndef UNION_FIND_ENGINE_CORE_ASSERT_SVH
`define UNION_FIND_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define UFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("union-find engine check failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define UFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("union-find engine check failed");

`endif

>>> hw/rtl/ufe_pkg.sv
// ---------------------------------------------------------------------------
// ufe_pkg
// Shared types and constants of the union-find engine: element index width,
// table size, command codes and the memory request bundle.
// ---------------------------------------------------------------------------
package ufe_pkg;

   // Index width is fixed by the word format; the table covers every index.
   localparam int IDX_W        = 10;
   localparam int NUM_ELEMENTS = 1 << IDX_W;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LAST_INDEX = idx_type'(NUM_ELEMENTS - 1);

   // Command codes carried in the command field.
   localparam logic CMD_UNION = 1'b0;
   localparam logic CMD_FIND  = 1'b1;

   // One write and one read request toward the parent table.
   typedef struct packed {
      logic    wr_en;
      idx_type wr_addr;
      idx_type wr_data;
      logic    rd_en;
      idx_type rd_addr;
   } mem_req_type;

endpackage

>>> hw/rtl/union_find_engine_core.sv
// ---------------------------------------------------------------------------
// union_find_engine_core
// Disjoint-set engine over a 1024-entry parent table held in one RAM.
// Find climbs to the root and compresses the path; union links the two
// elements by splicing. Every command returns one representative word.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_command, req_first_index,
//                                            req_second_index
//   rsp      out        rsp_valid/rsp_stall  rsp_representative
//
// After reset the table is cleared by a pass that writes each entry with its
// own index; req_stall stays high for that whole pass.
// Commands are processed one at a time, with up to one RAM write and one RAM
// read per cycle; the RAM returns read data in the cycle after the read. A
// find first climbs to the root and then walks the path again to compress it;
// a union reads both parents and then climbs one splicing step at a time.
// A result waits in the output register while rsp_stall is high, and the
// next request word is already taken while it waits.
// ---------------------------------------------------------------------------
module union_find_engine_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  logic [ufe_pkg::IDX_W-1:0] req_first_index,
   input  logic [ufe_pkg::IDX_W-1:0] req_second_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ufe_pkg::IDX_W-1:0] rsp_representative
);

   ufe_pkg::mem_req_type mem_req;
   ufe_pkg::idx_type     rd_data;
   ufe_pkg::idx_type     res_data;
   logic                 res_valid;
   logic                 res_taken;
   logic                 rsp_valid_ff, rsp_valid_in;
   ufe_pkg::idx_type     rsp_data_ff, rsp_data_in;

   // The parent table. Writes and reads issued in the same cycle always go
   // to different entries, and every read of an entry is issued in a later
   // cycle than its last write, so no forwarding is needed.
   ufe_ram #(
      .WIDTH (ufe_pkg::IDX_W),
      .DEPTH (ufe_pkg::NUM_ELEMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // The sequencer that walks the parent chains.
   ufe_walk u_walk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_command      (req_command),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_stall        (req_stall),
      .rd_data          (rd_data),
      .mem_req          (mem_req),
      .res_valid        (res_valid),
      .res_data         (res_data),
      .res_taken        (res_taken)
   );

   // Output register: a finished result moves in whenever the slot is empty
   // or its current word leaves in this cycle.
   assign res_taken = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_representative = rsp_data_ff;

endmodule

>>> hw/rtl/ufe_ram.sv
// ---------------------------------------------------------------------------
// ufe_ram
// Generic simple dual-port RAM: one write port, one read port and registered
// read data, valid in the cycle after the read.
// ---------------------------------------------------------------------------
module ufe_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ufe_walk.sv
// ---------------------------------------------------------------------------
// ufe_walk
// Command sequencer of the union-find engine. Clears the parent table after
// reset, then runs find (climb and path compression) and union (splicing)
// as read-modify-write walks over the table memory.
// ---------------------------------------------------------------------------
module ufe_walk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   input  ufe_pkg::idx_type     req_first_index,
   input  ufe_pkg::idx_type     req_second_index,
   output logic                 req_stall,
   input  ufe_pkg::idx_type     rd_data,
   output ufe_pkg::mem_req_type mem_req,
   output logic                 res_valid,
   output ufe_pkg::idx_type     res_data,
   input  logic                 res_taken
);

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_FIND_UP   = 8'b0000_0100,
      ST_FIND_COMP = 8'b0000_1000,
      ST_UNI_A     = 8'b0001_0000,
      ST_UNI_B     = 8'b0010_0000,
      ST_UNI_CMP   = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   ufe_pkg::idx_type clr_ff, clr_in;
   ufe_pkg::idx_type a_ff, a_in;     // find cursor, or first union cursor
   ufe_pkg::idx_type b_ff, b_in;     // second union cursor
   ufe_pkg::idx_type pa_ff, pa_in;   // parent of a_ff
   ufe_pkg::idx_type pb_ff, pb_in;   // parent of b_ff
   ufe_pkg::idx_type root_ff, root_in;
   ufe_pkg::idx_type res_ff, res_in;
   logic             first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      root_in  = root_ff;
      res_in   = res_ff;
      first_in = first_ff;
      mem_req  = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = clr_ff;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == ufe_pkg::LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               a_in            = req_first_index;
               b_in            = req_second_index;
               root_in         = req_first_index;
               first_in        = 1'b1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = req_first_index;
               if (req_command == ufe_pkg::CMD_FIND) begin
                  state_in = ST_FIND_UP;
               end else begin
                  state_in = ST_UNI_A;
               end
            end
         end
         ST_FIND_UP: begin
            // rd_data is the parent of root_ff.
            mem_req.rd_en = 1'b1;
            if (rd_data == root_ff) begin
               mem_req.rd_addr = a_ff;
               state_in        = ST_FIND_COMP;
            end else begin
               root_in         = rd_data;
               mem_req.rd_addr = rd_data;
            end
         end
         ST_FIND_COMP: begin
            // rd_data is the parent of a_ff; point a_ff at the root and climb.
            if (rd_data == root_ff || a_ff == root_ff) begin
               res_in   = root_ff;
               state_in = ST_DONE;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = a_ff;
               mem_req.wr_data = root_ff;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_data;
               a_in            = rd_data;
            end
         end
         ST_UNI_A: begin
            pa_in    = rd_data;
            first_in = 1'b0;
            if (first_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = b_ff;
               state_in        = ST_UNI_B;
            end else begin
               state_in = ST_UNI_CMP;
            end
         end
         ST_UNI_B: begin
            pb_in    = rd_data;
            state_in = ST_UNI_CMP;
         end
         ST_UNI_CMP: begin
            if (pa_ff == pb_ff) begin
               res_in   = pa_ff;
               state_in = ST_DONE;
            end else if (pa_ff < pb_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = a_ff;
               mem_req.wr_data = pb_ff;
               if (pa_ff == a_ff) begin
                  res_in   = pb_ff;
                  state_in = ST_DONE;
               end else begin
                  // Climb on the first side; the parent of b is unchanged.
                  a_in            = pa_ff;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = pa_ff;
                  state_in        = ST_UNI_A;
               end
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = b_ff;
               mem_req.wr_data = pa_ff;
               if (pb_ff == b_ff) begin
                  res_in   = pa_ff;
                  state_in = ST_DONE;
               end else begin
                  b_in            = pb_ff;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = pb_ff;
                  state_in        = ST_UNI_B;
               end
            end
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      root_ff <= root_in;
      res_ff  <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

>>> hw/rtl/ufe_checker.sv
// ---------------------------------------------------------------------------
// ufe_port_checker
// Port-level checks of the union-find engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "union_find_engine_core_assert.svh"

module ufe_port_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_command,
   input logic [ufe_pkg::IDX_W-1:0] req_first_index,
   input logic [ufe_pkg::IDX_W-1:0] req_second_index,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [ufe_pkg::IDX_W-1:0] rsp_representative
);

   // The table clearing pass keeps the input closed right after reset.
   `UFE_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, req_stall)

   // An accepted command keeps the input closed in the cycle after it is taken.
   `UFE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A new result only appears after the sequencer was busy.
   `UFE_ASSERT_NOW(a_result_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // A stalled result word holds.
   `UFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_representative))

endmodule

bind union_find_engine_core ufe_port_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_command        (req_command),
   .req_first_index    (req_first_index),
   .req_second_index   (req_second_index),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_representative (rsp_representative)
);

>>> verif/ufe_checker.sv
// ---------------------------------------------------------------------------
// ufe_checker
// Watches both channels of the union-find engine and keeps its own copy of
// the parent table. Each accepted request word is run through that copy and
// the representative it yields is queued. Each accepted response word is
// compared with the oldest queued one.
// ---------------------------------------------------------------------------
module ufe_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_command,
   input  ufe_pkg::idx_type     req_first_index,
   input  ufe_pkg::idx_type     req_second_index,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ufe_pkg::idx_type     rsp_representative,
   output int                   error_count,
   output int                   pending_count
);
   import ufe_pkg::*;

   idx_type parent_of [NUM_ELEMENTS];
   idx_type expected_reps [$];

   // Climb to the root, then point every entry on the path straight at it.
   function automatic idx_type trace_root(idx_type start);
      idx_type root;
      idx_type walk;
      idx_type nxt;
      root = start;
      while (parent_of[root] != root)
         root = parent_of[root];
      walk = start;
      while (parent_of[walk] != root && walk != root) begin
         nxt             = parent_of[walk];
         parent_of[walk] = root;
         walk            = nxt;
      end
      return root;
   endfunction

   // Splicing union: the side with the smaller parent is relinked and climbs.
   function automatic idx_type splice_join(idx_type a, idx_type b);
      idx_type up;
      logic    done;
      done = 1'b0;
      while (!done && parent_of[a] != parent_of[b]) begin
         if (parent_of[a] < parent_of[b]) begin
            if (parent_of[a] == a) begin
               parent_of[a] = parent_of[b];
               done         = 1'b1;
            end else begin
               up           = parent_of[a];
               parent_of[a] = parent_of[b];
               a            = up;
            end
         end else begin
            if (parent_of[b] == b) begin
               parent_of[b] = parent_of[a];
               done         = 1'b1;
            end else begin
               up           = parent_of[b];
               parent_of[b] = parent_of[a];
               b            = up;
            end
         end
      end
      return parent_of[a];
   endfunction

   always @(posedge clock) begin
      idx_type want;
      if (reset) begin
         for (int k = 0; k < NUM_ELEMENTS; k++)
            parent_of[k] = idx_type'(k);
         expected_reps.delete();
         error_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_command == CMD_FIND)
               expected_reps.push_back(trace_root(req_first_index));
            else
               expected_reps.push_back(splice_join(req_first_index, req_second_index));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reps.size() == 0) begin
               $error("unexpected response word: representative %0d", rsp_representative);
               error_count++;
            end else begin
               want = expected_reps.pop_front();
               if (rsp_representative !== want) begin
                  $error("field representative: expected %0d, actual %0d",
                         want, rsp_representative);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_reps.size();
   end

endmodule

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for union_find_engine_core. A directed opening covers
// the index extremes, both commands, self-union and already-joined unions;
// clustered random commands then build and compress deep trees under three
// idling regimes. Checking is done by ufe_checker beside the engine.
// ---------------------------------------------------------------------------
module tb;
   import ufe_pkg::*;

   // Random words per idling regime; three regimes give 1434 in total.
   localparam int     WORDS_PER_PHASE = 478;
   // Safety net far above the slowest legal run, in clock cycles.
   localparam longint TIMEOUT_CYCLES  = 20_000_000;

   logic    clock              = 1'b0;
   logic    reset              = 1'b1;
   logic    req_valid          = 1'b0;
   logic    req_command        = CMD_UNION;
   idx_type req_first_index    = '0;
   idx_type req_second_index   = '0;
   logic    rsp_stall          = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   idx_type rsp_representative;

   int error_count;
   int pending_count;

   // Percentages of cycles in which the sender holds back a word and the
   // receiver stalls the response channel.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   always #10 clock = ~clock;

   union_find_engine_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_index    (req_first_index),
      .req_second_index   (req_second_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_representative (rsp_representative)
   );

   ufe_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_index    (req_first_index),
      .req_second_index   (req_second_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_representative (rsp_representative),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // The receiver decides each cycle afresh whether to stall, so stalls land
   // on every phase of the engine's work, including while a result waits.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Offers one word and returns at the edge where it is taken. The task is
   // always entered just after a rising edge, so each assignment below is
   // the only one to its signal in that time step. When no idle cycle is
   // drawn, valid stays high from the previous word without a dip.
   task automatic send_word(logic cmd, idx_type first_idx, idx_type second_idx);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_first_index  <= first_idx;
      req_second_index <= second_idx;
      // Values read right after the edge are the ones the engine sampled.
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Random commands are drawn mostly from a small cluster of neighboring
   // elements, so unions keep merging the same sets and chains grow long
   // enough for splicing and path compression to do real work. The cluster
   // moves every few dozen words; a share of full-range words stays mixed in.
   task automatic run_random_phase(int word_total);
      idx_type cluster_base;
      int      cluster_span;
      idx_type first_idx;
      idx_type second_idx;
      logic    cmd;
      for (int n = 0; n < word_total; n++) begin
         if (n % 32 == 0) begin
            cluster_base = idx_type'($urandom_range(0, LAST_INDEX));
            cluster_span = $urandom_range(4, 48);
         end
         if ($urandom_range(0, 99) < 10) begin
            first_idx  = idx_type'($urandom_range(0, LAST_INDEX));
            second_idx = idx_type'($urandom_range(0, LAST_INDEX));
         end else begin
            first_idx  = idx_type'(cluster_base + $urandom_range(0, cluster_span - 1));
            second_idx = idx_type'(cluster_base + $urandom_range(0, cluster_span - 1));
         end
         cmd = ($urandom_range(0, 99) < 65) ? CMD_UNION : CMD_FIND;
         // Find ignores the second index, so it gets arbitrary bits there.
         if (cmd == CMD_FIND)
            second_idx = idx_type'($urandom_range(0, LAST_INDEX));
         send_word(cmd, first_idx, second_idx);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. The engine first clears its table and holds
      // req_stall high meanwhile; send_word simply waits that out.
      send_word(CMD_FIND,  '0,         '0);
      send_word(CMD_FIND,  LAST_INDEX, LAST_INDEX);
      send_word(CMD_UNION, '0,         LAST_INDEX);
      send_word(CMD_FIND,  '0,         LAST_INDEX);
      // A union of an element with itself writes nothing.
      send_word(CMD_UNION, 10'd5,      10'd5);
      // Build a chain, then unite two members already in the same set.
      send_word(CMD_UNION, 10'd10,     10'd11);
      send_word(CMD_UNION, 10'd11,     10'd12);
      send_word(CMD_UNION, 10'd12,     10'd13);
      send_word(CMD_UNION, 10'd13,     10'd10);
      send_word(CMD_UNION, 10'd10,     10'd13);
      send_word(CMD_UNION, 10'd20,     10'd10);
      send_word(CMD_FIND,  10'd10,     10'd0);
      send_word(CMD_FIND,  10'd20,     LAST_INDEX);
      // Alternating bit patterns on both index fields.
      send_word(CMD_UNION, 10'h2AA,    10'h155);
      send_word(CMD_FIND,  10'h155,    10'h2AA);
      send_word(CMD_UNION, 10'h200,    10'h1FF);
      send_word(CMD_UNION, LAST_INDEX, 10'd13);
      send_word(CMD_UNION, 10'd1022,   10'd1);
      send_word(CMD_FIND,  10'd1,      10'd0);
      send_word(CMD_FIND,  10'd12,     10'd0);

      // Sender idles lightly while the receiver stalls heavily.
      sender_idle_pct    = 24;
      receiver_stall_pct <= 65;
      run_random_phase(WORDS_PER_PHASE);

      // The other way round.
      sender_idle_pct    = 65;
      receiver_stall_pct <= 24;
      run_random_phase(WORDS_PER_PHASE);

      // Neither side idles, so words go back to back.
      sender_idle_pct    = 0;
      receiver_stall_pct <= 0;
      run_random_phase(WORDS_PER_PHASE);

      req_valid <= 1'b0;
      while (pending_count != 0)
         @(posedge clock);
      // Every word produces a response, so a short settle is enough to catch
      // any spurious extra response word.
      repeat (50) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ufe_pkg.sv
hw/rtl/ufe_ram.sv
hw/rtl/ufe_walk.sv
hw/rtl/union_find_engine_core.sv
hw/rtl/ufe_checker.sv
verif/ufe_checker.sv
verif/tb.sv
